// ----- sv/tdi_pkg.sv -----
// ----------------------------------------------------------------------------
// tdi_pkg: shared types and constants
// Register map, widths and queue entry type for the ToF depth block.
// ----------------------------------------------------------------------------
`default_nettype none
package tdi_pkg;
  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 240;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    REG_MODEL   = 3'd0,
    REG_CSQ     = 3'd1,
    REG_CAVG    = 3'd2,
    REG_CDIFF   = 3'd3,
    REG_CCONST  = 3'd4,
    REG_THRF    = 3'd5,
    REG_MAXR    = 3'd6
  } reg_idx_t;

  localparam logic [1:0] MODEL_QUAD = 2'd1;
  localparam logic [1:0] MODEL_DIFF = 2'd2;

  // classified pixel handed from front to back
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] amp;
  } pix_t;

  typedef struct packed {
    logic [1:0]  model;
    logic [31:0] csq;
    logic [31:0] cavg;
    logic [31:0] cdiff;
    logic [31:0] cconst;
    logic [15:0] maxr;
  } cfg_t;
endpackage
`default_nettype wire

// ----- sv/tof_depth_from_intensity.sv -----
// ----------------------------------------------------------------------------
// tof_depth_from_intensity: ToF depth from intensity pixels
// Accepts 1 item per cycle inside a pass while busy is low.
// Statistics pass end: busy while the bit-serial threshold divide runs.
// Depth pass end: the back end waits for the two mean divides.
// Results cannot be stalled. Synchronous active-low reset clears control and accumulator state, not data registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tof_depth_from_intensity import tdi_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [15:0] in_intensity_a,
  input  wire logic [15:0] in_intensity_b,
  input  wire logic [15:0] in_amplitude,
  input  wire logic        in_frame_end,
  output logic             out_strobe,
  output logic [15:0]      out_depth_mm,
  output logic             out_pixel_valid,
  output logic [15:0]      out_amplitude_out,
  output logic             out_frame_done,
  output logic [15:0]      out_mean_depth_mm,
  output logic [15:0]      out_mean_valid_amplitude,
  output logic [16:0]      out_valid_pixels,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam longint PIX = longint'(FRAME_WIDTH) * longint'(FRAME_HEIGHT);
  localparam int PIXEL_LIMIT = (PIX < 131071) ? int'(PIX) : 131071;

  cfg_t        cfg_r;
  logic [15:0] thrf_r;
  logic        acc, dbusy, push, full, afull, nempty, pop, idle, pushq;
  pix_t        ppix, qpix;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.model <= '0;
      cfg_r.csq <= '0;
      cfg_r.cavg <= '0;
      cfg_r.cdiff <= '0;
      cfg_r.cconst <= '0;
      cfg_r.maxr <= 16'hFFFF;
      thrf_r <= 16'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_MODEL:  cfg_r.model <= pwdata[1:0];
        REG_CSQ:    cfg_r.csq <= pwdata;
        REG_CAVG:   cfg_r.cavg <= pwdata;
        REG_CDIFF:  cfg_r.cdiff <= pwdata;
        REG_CCONST: cfg_r.cconst <= pwdata;
        REG_THRF:   thrf_r <= pwdata[15:0];
        REG_MAXR:   cfg_r.maxr <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODEL:  prdata = {30'b0, cfg_r.model};
      REG_CSQ:    prdata = cfg_r.csq;
      REG_CAVG:   prdata = cfg_r.cavg;
      REG_CDIFF:  prdata = cfg_r.cdiff;
      REG_CCONST: prdata = cfg_r.cconst;
      REG_THRF:   prdata = {16'b0, thrf_r};
      REG_MAXR:   prdata = {16'b0, cfg_r.maxr};
      default:    prdata = '0;
    endcase
  end

  // a statistics item must not pass the threshold divide, nor a depth item
  // overtake; stall while the divider runs or the queue is almost full
  assign busy = dbusy || afull || full || (!idle && !nempty && 1'b0);
  assign acc = start && !busy;

  tdi_front #(.PIXEL_LIMIT(PIXEL_LIMIT)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .op(in_operation),
    .a(in_intensity_a), .b(in_intensity_b), .amp(in_amplitude),
    .last(in_frame_end), .thr_factor(thrf_r), .div_busy(dbusy),
    .push(push), .push_pix(ppix)
  );

  assign pushq = push;

  tdi_queue #(.DEPTH(QDEPTH)) u_q (
    .clk(clk), .rst_n(rst_n), .push(pushq), .din(ppix), .pop(pop),
    .nempty(nempty), .full(full), .almost_full(afull), .dout(qpix)
  );

  tdi_back #(.PIXEL_LIMIT(PIXEL_LIMIT)) u_back (
    .clk(clk), .rst_n(rst_n), .pop_ok(nempty), .pix(qpix), .cfg(cfg_r),
    .pop(pop), .idle(idle), .o_stb(out_strobe), .o_depth(out_depth_mm),
    .o_valid(out_pixel_valid), .o_amp(out_amplitude_out),
    .o_done(out_frame_done), .o_mdepth(out_mean_depth_mm),
    .o_mamp(out_mean_valid_amplitude), .o_cnt(out_valid_pixels)
  );
endmodule
`default_nettype wire

// ----- sv/tdi_div.sv -----
// ----------------------------------------------------------------------------
// tdi_div: restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tdi_div import tdi_pkg::*; #(
  parameter int NW = 40,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (go) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (go) den_r <= den;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule
`default_nettype wire

// ----- sv/tdi_front.sv -----
// ----------------------------------------------------------------------------
// tdi_front: statistics pass and pixel classification
// Accumulates nonzero amplitudes, forms the threshold at pass end, and
// classifies depth-pass pixels into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tdi_front import tdi_pkg::*; #(
  parameter int PIXEL_LIMIT = 76800
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic        op,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  input  wire logic [15:0] amp,
  input  wire logic        last,
  input  wire logic [15:0] thr_factor,
  output logic             div_busy,
  output logic             push,
  output pix_t             push_pix
);
  localparam logic [16:0] LIM = 17'(PIXEL_LIMIT);
  logic [32:0] sum_r;
  logic [16:0] cnt_r;
  logic [35:0] thr_r;
  logic        dbusy_r, dgo_r;
  logic [36:0] num_r;
  logic [16:0] den_r;
  logic        ddone;
  logic [36:0] quo;
  logic [32:0] sum_add;
  logic [16:0] cnt_add;
  logic        take;
  logic [35:0] prod;

  assign take = acc && !op && amp != 16'd0 && cnt_r < LIM;
  assign sum_add = take ? sum_r + 33'(amp) : sum_r;
  assign cnt_add = take ? cnt_r + 17'd1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      thr_r <= '0;
      dbusy_r <= 1'b0;
      dgo_r <= 1'b0;
    end else begin
      dgo_r <= 1'b0;
      if (acc && !op && last) begin
        sum_r <= '0;
        cnt_r <= '0;
        if (cnt_add == 17'd0) begin
          thr_r <= '0;
        end else begin
          dbusy_r <= 1'b1;
          dgo_r <= 1'b1;
        end
      end else begin
        sum_r <= sum_add;
        cnt_r <= cnt_add;
      end
      if (ddone) begin
        dbusy_r <= 1'b0;
        thr_r <= prod;
      end
    end
    if (acc && !op && last) begin
      num_r <= {sum_add, 4'b0};
      den_r <= cnt_add;
    end
  end

  // mean fits in 20 bits
  assign prod = 36'(quo[19:0]) * 36'(thr_factor);

  tdi_div #(.NW(37), .DW(17)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo_r), .num(num_r), .den(den_r),
    .done(ddone), .quo(quo)
  );

  assign div_busy = dbusy_r;
  assign push = acc && op;
  always_comb begin
    push_pix.valid = ({amp, 16'b0} >= thr_r) && a != 16'd0;
    push_pix.last = last;
    push_pix.a = a;
    push_pix.b = b;
    push_pix.amp = amp;
  end
endmodule
`default_nettype wire

// ----- sv/tdi_back.sv -----
// ----------------------------------------------------------------------------
// tdi_back: depth model and frame means
// Pipelined model evaluation, clamp, sums; dividers at frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module tdi_back import tdi_pkg::*; #(
  parameter int PIXEL_LIMIT = 76800
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_ok,
  input  pix_t             pix,
  input  cfg_t             cfg,
  output logic             pop,
  output logic             idle,
  output logic             o_stb,
  output logic [15:0]      o_depth,
  output logic             o_valid,
  output logic [15:0]      o_amp,
  output logic             o_done,
  output logic [15:0]      o_mdepth,
  output logic [15:0]      o_mamp,
  output logic [16:0]      o_cnt
);
  localparam logic [16:0] LIM = 17'(PIXEL_LIMIT);
  // stage 1: sum and difference; products in stage 2
  logic        s1_r, s2_r, s3_r;
  pix_t        p1_r, p2_r, p3_r;
  logic [16:0] s_r;
  logic signed [17:0] d_r;
  logic [33:0] q_r;
  logic signed [49:0] avg_r, dif_r;
  logic signed [63:0] sqh_r, sql_r;
  logic signed [63:0] acc_r;
  logic        wait_r;
  logic        dgo_r, dd0, dd1;
  logic [32:0] dsum_r, asum_r;
  logic [16:0] vcnt_r;
  logic [33:0] n0_r, n1_r;
  logic [33:0] qd, qa;
  pix_t        fin_r;
  logic [15:0] fdep_r;
  logic signed [63:0] acc_n, rnd;
  logic [15:0] dep;
  logic        blocked;
  logic signed [53:0] sqh_m;
  logic signed [45:0] sql_m;

  assign blocked = wait_r || (s1_r && p1_r.last) || (s2_r && p2_r.last) ||
                   (s3_r && p3_r.last);
  assign pop = pop_ok && !blocked;
  assign idle = !blocked && !s1_r && !s2_r && !s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
    end else begin
      s1_r <= pop;
    end
    p1_r <= pix;
    s_r <= 17'(pix.a) + 17'(pix.b);
    d_r <= $signed({2'b0, pix.a}) - $signed({2'b0, pix.b});
  end

  assign sqh_m = $signed({{22{cfg.csq[31]}}, cfg.csq}) * $signed({33'b0, q_r[33:13]});
  assign sql_m = $signed({{14{cfg.csq[31]}}, cfg.csq}) * $signed({33'b0, q_r[12:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= 1'b0;
      s3_r <= 1'b0;
    end else begin
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
    p2_r <= p1_r;
    q_r <= 34'(s_r) * 34'(s_r);
    avg_r <= $signed({{18{cfg.cavg[31]}}, cfg.cavg}) * $signed({33'b0, s_r});
    dif_r <= ($signed({{18{cfg.cdiff[31]}}, cfg.cdiff}) * $signed({{32{d_r[17]}}, d_r})) <<< 1;
    p3_r <= p2_r;
    sqh_r <= 64'(sqh_m);
    sql_r <= 64'(sql_m) >>> 13;
    acc_r <= 64'(avg_r) + (64'($signed(cfg.cconst)) <<< 9) +
             (cfg.model == MODEL_DIFF ? 64'(dif_r) : 64'sd0);
  end

  always_comb begin
    acc_n = acc_r + (cfg.model == MODEL_QUAD ? sqh_r + sql_r : 64'sd0);
    rnd = (acc_n + 64'sd1048576) >>> 21;
    if (!p3_r.valid || acc_n <= 64'sd0) dep = '0;
    else if (rnd > 64'(cfg.maxr)) dep = cfg.maxr;
    else dep = rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_stb <= 1'b0;
      wait_r <= 1'b0;
      dgo_r <= 1'b0;
      dsum_r <= '0;
      asum_r <= '0;
      vcnt_r <= '0;
    end else begin
      o_stb <= 1'b0;
      dgo_r <= 1'b0;
      if (s3_r) begin
        logic [32:0] ds, as;
        logic [16:0] vc;
        ds = dsum_r;
        as = asum_r;
        vc = vcnt_r;
        if (p3_r.valid && vcnt_r < LIM) begin
          ds = dsum_r + 33'(dep);
          as = asum_r + 33'(p3_r.amp);
          vc = vcnt_r + 17'd1;
        end
        if (p3_r.last) begin
          dsum_r <= '0;
          asum_r <= '0;
          vcnt_r <= '0;
          wait_r <= 1'b1;
          dgo_r <= 1'b1;
          n0_r <= 34'(ds) + 34'(vc[16:1]);
          n1_r <= 34'(as) + 34'(vc[16:1]);
          o_cnt <= vc;
          fin_r <= p3_r;
          fdep_r <= dep;
        end else begin
          dsum_r <= ds;
          asum_r <= as;
          vcnt_r <= vc;
          o_stb <= 1'b1;
          o_depth <= dep;
          o_valid <= p3_r.valid;
          o_amp <= p3_r.amp;
          o_done <= 1'b0;
          o_mdepth <= '0;
          o_mamp <= '0;
          o_cnt <= '0;
        end
      end
      if (dd0 && dd1) begin
        wait_r <= 1'b0;
        o_stb <= 1'b1;
        o_depth <= fdep_r;
        o_valid <= fin_r.valid;
        o_amp <= fin_r.amp;
        o_done <= 1'b1;
        o_mdepth <= o_cnt == '0 ? 16'd0 : qd[15:0];
        o_mamp <= o_cnt == '0 ? 16'd0 : qa[15:0];
      end
    end
  end

  tdi_div #(.NW(34), .DW(17)) u_divd (
    .clk(clk), .rst_n(rst_n), .go(dgo_r), .num(n0_r), .den(o_cnt),
    .done(dd0), .quo(qd)
  );
  tdi_div #(.NW(34), .DW(17)) u_diva (
    .clk(clk), .rst_n(rst_n), .go(dgo_r), .num(n1_r), .den(o_cnt),
    .done(dd1), .quo(qa)
  );
endmodule
`default_nettype wire

// ----- sv/tdi_queue.sv -----
// ----------------------------------------------------------------------------
// tdi_queue: small FIFO between front and back
// Register based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tdi_queue import tdi_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  pix_t      din,
  input  wire logic pop,
  output logic      nempty,
  output logic      full,
  output logic      almost_full,
  output pix_t      dout
);
  localparam int AW = $clog2(DEPTH);
  pix_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end
  assign nempty = cnt_r != '0;
  assign full = cnt_r == (AW+1)'(DEPTH);
  assign almost_full = cnt_r >= (AW+1)'(DEPTH - 1);
  assign dout = mem_r[rp_r];
endmodule
`default_nettype wire
